// File: sv/assert_macros.svh
// assertion macros shared by the camera tracker rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, skipped while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

// File: sv/sfc_pkg.sv
// shared types, constants and helpers of the smooth follow camera
// no dependencies
`default_nettype none
package sfc_pkg;
	localparam int PosW      = 24;
	localparam int ErrW      = 26;
	localparam int MulW      = 32;
	localparam int ProdW     = 2 * MulW;
	localparam int MulDigitW = 4;
	localparam int MulDigits = MulW / MulDigitW;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 24;

	localparam logic [1:0] OpFollow = 2'd0;
	localparam logic [1:0] OpShake  = 2'd1;
	localparam logic [1:0] OpPlace  = 2'd2;

	localparam logic [CfgIdxW-1:0] RegViewWidth  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegViewHeight = 3'd1;
	localparam logic [CfgIdxW-1:0] RegFollowGain = 3'd2;
	localparam logic [CfgIdxW-1:0] RegBoundLeft  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegBoundRight = 3'd4;
	localparam logic [CfgIdxW-1:0] RegBoundTop   = 3'd5;
	localparam logic [CfgIdxW-1:0] RegBoundBot   = 3'd6;

	// ceil(2^36 / 1000): exact floor division by 1000 for operands below 2^36 / 264
	localparam logic [26:0] RecipK    = 27'd68719477;
	localparam logic [25:0] HalfDiv   = 26'd500;
	localparam logic [10:0] JitterMax = 11'd2000;
	localparam logic [10:0] JitterMid = 11'd1000;

	typedef logic signed [PosW-1:0] pos_t;

	typedef struct packed {
		logic            start;
		logic [MulW-1:0] a;
		logic [MulW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             done;
		logic [ProdW-1:0] p;
	} mul_rsp_t;

	function automatic pos_t sat_pos(input logic signed [35:0] v);
		pos_t r;
		if (v > 36'sd8388607) begin
			r = {1'b0, {(PosW-1){1'b1}}};
		end else if (v < -36'sd8388608) begin
			r = {1'b1, {(PosW-1){1'b0}}};
		end else begin
			r = v[PosW-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: sv/sfc_in_if.sv
// command channel of the camera tracker: valid/ready plus item fields
// depends on sfc_pkg for widths
`default_nettype none
interface sfc_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     operation;
	logic signed [sfc_pkg::PosW-1:0] target_x;
	logic signed [sfc_pkg::PosW-1:0] target_y;
	logic [15:0]                    step_time;
	logic [10:0]                    jitter_x;
	logic [10:0]                    jitter_y;
	logic [15:0]                    shake_strength;
	logic [23:0]                    shake_time;
	logic [15:0]                    shake_fade;

	modport source (
		output valid, operation, target_x, target_y, step_time, jitter_x, jitter_y,
		       shake_strength, shake_time, shake_fade,
		input  ready
	);
	modport sink (
		input  valid, operation, target_x, target_y, step_time, jitter_x, jitter_y,
		       shake_strength, shake_time, shake_fade,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/sfc_out_if.sv
// result channel of the camera tracker: valid/ready plus view position
// depends on sfc_pkg for widths
`default_nettype none
interface sfc_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [sfc_pkg::PosW-1:0] view_x;
	logic signed [sfc_pkg::PosW-1:0] view_y;
	logic                           shaking;

	modport source (output valid, view_x, view_y, shaking, input ready);
	modport sink (input valid, view_x, view_y, shaking, output ready);
endinterface
`default_nettype wire

// File: sv/smooth_follow_camera_with_shake_top.sv
// follow step: StExec, then StLaunch, StWait, StPost per product, StClamp per axis, StOut;
// place and shake start: StExec, StOut; a new item is taken only in StIdle, the cycle after
// the result is loaded; the shared serial multiplier does 8 digit steps per product,
// 3 products per follow step plus 5 more while shaking
// asynchronous active-low reset clears position, shake state, sequencer and configuration at once
// depends on sfc_pkg, sfc_in_if, sfc_out_if, sfc_mul and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module smooth_follow_camera_with_shake_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sfc_in_if.sink                              cmd,
	sfc_out_if.source                           view,
	input  wire logic                           cfg_wen,
	input  wire logic [sfc_pkg::CfgIdxW-1:0]    cfg_idx,
	input  wire logic [sfc_pkg::CfgDataW-1:0]   cfg_data
);
	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StExec   = 3'd1;
	localparam logic [2:0] StLaunch = 3'd2;
	localparam logic [2:0] StWait   = 3'd3;
	localparam logic [2:0] StPost   = 3'd4;
	localparam logic [2:0] StClamp  = 3'd5;
	localparam logic [2:0] StOut    = 3'd6;

	localparam logic [2:0] PhGain  = 3'd0;
	localparam logic [2:0] PhMove  = 3'd1;
	localparam logic [2:0] PhShake = 3'd2;
	localparam logic [2:0] PhRecip = 3'd3;
	localparam logic [2:0] PhLoss  = 3'd4;

	// configuration
	logic [11:0]   vw_q;
	logic [11:0]   vh_q;
	logic [15:0]   gain_q;
	sfc_pkg::pos_t bl_q;
	sfc_pkg::pos_t br_q;
	sfc_pkg::pos_t bt_q;
	sfc_pkg::pos_t bb_q;

	// camera state
	sfc_pkg::pos_t pos_x_q;
	sfc_pkg::pos_t pos_y_q;
	logic [15:0]   amp_q;
	logic [23:0]   rem_q;
	logic [15:0]   fade_q;

	// sequencer
	logic [2:0] state_q;
	logic [2:0] phase_q;
	logic       ax_q;
	logic       ov_q;

	// latched item
	logic [1:0]    op_q;
	sfc_pkg::pos_t tx_q;
	sfc_pkg::pos_t ty_q;
	logic [15:0]   dt_q;
	logic [10:0]   jx_q;
	logic [10:0]   jy_q;
	logic [15:0]   str_q;
	logic [23:0]   stime_q;
	logic [15:0]   sfade_q;

	// work registers
	logic signed [sfc_pkg::ErrW-1:0]  errx_q;
	logic signed [sfc_pkg::ErrW-1:0]  erry_q;
	logic [sfc_pkg::MulW-1:0]         gd_q;
	logic [sfc_pkg::ProdW-1:0]        prod_q;
	sfc_pkg::pos_t                    psat_q;
	logic [25:0]                      n_q;
	sfc_pkg::pos_t                    ox_q;
	sfc_pkg::pos_t                    oy_q;
	logic                             osh_q;

	sfc_pkg::mul_req_t mreq;
	sfc_pkg::mul_rsp_t mrsp;

	logic                             cmd_xfer;
	logic                             out_load;
	sfc_pkg::pos_t                    pos_sel;
	sfc_pkg::pos_t                    lo_sel;
	sfc_pkg::pos_t                    hi_sel;
	logic [11:0]                      size_sel;
	logic signed [sfc_pkg::ErrW-1:0]  err_sel;
	logic                             err_neg;
	logic [sfc_pkg::ErrW-1:0]         err_abs;
	logic signed [35:0]               pos_ext;
	logic [33:0]                      move_mag;
	logic signed [35:0]               move_val;
	sfc_pkg::pos_t                    follow_pos;
	logic [10:0]                      jit_sel;
	logic [10:0]                      jit_c;
	logic                             jit_neg;
	logic [10:0]                      jit_mag;
	logic [16:0]                      shake_mag;
	logic signed [35:0]               shake_val;
	sfc_pkg::pos_t                    shake_pos;
	logic signed [25:0]               psat_ext;
	logic signed [25:0]               span;
	logic signed [25:0]               hi_ext;
	logic signed [25:0]               hi_less;
	sfc_pkg::pos_t                    clamp_pos;
	logic [32:0]                      loss_sum;
	logic [16:0]                      loss;
	logic [15:0]                      amp_next;
	logic [23:0]                      rem_next;

	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign out_load  = (state_q == StOut) && (!ov_q || view.ready);
	assign cmd.ready = (state_q == StIdle);

	assign view.valid   = ov_q;
	assign view.view_x  = ox_q;
	assign view.view_y  = oy_q;
	assign view.shaking = osh_q;

	// per-axis selection
	always_comb begin
		pos_sel  = ax_q ? pos_y_q : pos_x_q;
		lo_sel   = ax_q ? bt_q : bl_q;
		hi_sel   = ax_q ? bb_q : br_q;
		size_sel = ax_q ? vh_q : vw_q;
		err_sel  = ax_q ? erry_q : errx_q;
		jit_sel  = ax_q ? jy_q : jx_q;
		err_neg  = err_sel[sfc_pkg::ErrW-1];
		err_abs  = err_neg ? 26'(-err_sel) : 26'(err_sel);
		pos_ext  = {{12{pos_sel[23]}}, pos_sel};
	end

	// follow move, rounded half away from zero
	always_comb begin
		move_mag   = {1'b0, prod_q[56:24]} + {33'b0, prod_q[23]};
		move_val   = err_neg ? -$signed({2'b0, move_mag}) : $signed({2'b0, move_mag});
		follow_pos = sfc_pkg::sat_pos(pos_ext + move_val);
	end

	// shake offset
	always_comb begin
		jit_c     = (jit_sel > sfc_pkg::JitterMax) ? sfc_pkg::JitterMax : jit_sel;
		jit_neg   = jit_c < sfc_pkg::JitterMid;
		jit_mag   = jit_neg ? (sfc_pkg::JitterMid - jit_c) : (jit_c - sfc_pkg::JitterMid);
		shake_mag = prod_q[52:36];
		shake_val = jit_neg ? -$signed({19'b0, shake_mag}) : $signed({19'b0, shake_mag});
		shake_pos = sfc_pkg::sat_pos(pos_ext + shake_val);
	end

	// bounds, low bound first
	always_comb begin
		psat_ext = {{2{psat_q[23]}}, psat_q};
		span     = $signed({6'b0, size_sel, 8'b0});
		hi_ext   = {{2{hi_sel[23]}}, hi_sel};
		hi_less  = hi_ext - span;
		if (psat_q < lo_sel) begin
			clamp_pos = lo_sel;
		end else if ((psat_ext + span) > hi_ext) begin
			clamp_pos = sfc_pkg::sat_pos({{10{hi_less[25]}}, hi_less});
		end else begin
			clamp_pos = psat_q;
		end
	end

	// decay
	always_comb begin
		loss_sum = {1'b0, prod_q[31:0]} + 33'h0_0000_8000;
		loss     = loss_sum[32:16];
		amp_next = (loss >= {1'b0, amp_q}) ? 16'd0 : (amp_q - loss[15:0]);
		rem_next = ({8'b0, dt_q} >= rem_q) ? 24'd0 : (rem_q - {8'b0, dt_q});
	end

	always_comb begin
		mreq.start = (state_q == StLaunch);
		case (phase_q)
			PhGain: begin
				mreq.a = {16'b0, gain_q};
				mreq.b = {16'b0, dt_q};
			end
			PhMove: begin
				mreq.a = {7'b0, err_abs[24:0]};
				mreq.b = gd_q;
			end
			PhShake: begin
				mreq.a = {16'b0, amp_q};
				mreq.b = {22'b0, jit_mag[9:0]};
			end
			PhRecip: begin
				mreq.a = {5'b0, sfc_pkg::RecipK};
				mreq.b = {6'b0, n_q};
			end
			PhLoss: begin
				mreq.a = {16'b0, fade_q};
				mreq.b = {16'b0, dt_q};
			end
			default: begin
				mreq.a = '0;
				mreq.b = '0;
			end
		endcase
	end

	sfc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q   <= '0;
			vh_q   <= '0;
			gain_q <= '0;
			bl_q   <= '0;
			br_q   <= '0;
			bt_q   <= '0;
			bb_q   <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				sfc_pkg::RegViewWidth:  vw_q   <= cfg_data[11:0];
				sfc_pkg::RegViewHeight: vh_q   <= cfg_data[11:0];
				sfc_pkg::RegFollowGain: gain_q <= cfg_data[15:0];
				sfc_pkg::RegBoundLeft:  bl_q   <= cfg_data;
				sfc_pkg::RegBoundRight: br_q   <= cfg_data;
				sfc_pkg::RegBoundTop:   bt_q   <= cfg_data;
				sfc_pkg::RegBoundBot:   bb_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			phase_q <= PhGain;
			ax_q    <= 1'b0;
			ov_q    <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			amp_q   <= '0;
			rem_q   <= '0;
			fade_q  <= '0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (view.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (cmd_xfer) begin
						state_q <= StExec;
					end
				end
				StExec: begin
					case (op_q)
						sfc_pkg::OpFollow: begin
							phase_q <= PhGain;
							ax_q    <= 1'b0;
							state_q <= StLaunch;
						end
						sfc_pkg::OpShake: begin
							amp_q   <= str_q;
							rem_q   <= stime_q;
							fade_q  <= sfade_q;
							state_q <= StOut;
						end
						sfc_pkg::OpPlace: begin
							pos_x_q <= tx_q;
							pos_y_q <= ty_q;
							state_q <= StOut;
						end
						default: state_q <= StOut;
					endcase
				end
				StLaunch: state_q <= StWait;
				StWait: begin
					if (mrsp.done) begin
						state_q <= StPost;
					end
				end
				StPost: begin
					case (phase_q)
						PhGain: begin
							phase_q <= PhMove;
							ax_q    <= 1'b0;
							state_q <= StLaunch;
						end
						PhMove: state_q <= StClamp;
						PhShake: begin
							phase_q <= PhRecip;
							state_q <= StLaunch;
						end
						PhRecip: begin
							if (ax_q) begin
								pos_y_q <= shake_pos;
								phase_q <= PhLoss;
							end else begin
								pos_x_q <= shake_pos;
								ax_q    <= 1'b1;
								phase_q <= PhShake;
							end
							state_q <= StLaunch;
						end
						PhLoss: begin
							amp_q   <= amp_next;
							rem_q   <= rem_next;
							state_q <= StOut;
						end
						default: state_q <= StOut;
					endcase
				end
				StClamp: begin
					if (ax_q) begin
						pos_y_q <= clamp_pos;
						if (rem_q != 24'd0) begin
							ax_q    <= 1'b0;
							phase_q <= PhShake;
							state_q <= StLaunch;
						end else begin
							state_q <= StOut;
						end
					end else begin
						pos_x_q <= clamp_pos;
						ax_q    <= 1'b1;
						state_q <= StLaunch;
					end
				end
				StOut: begin
					if (out_load) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q    <= cmd.operation;
			tx_q    <= cmd.target_x;
			ty_q    <= cmd.target_y;
			dt_q    <= cmd.step_time;
			jx_q    <= cmd.jitter_x;
			jy_q    <= cmd.jitter_y;
			str_q   <= cmd.shake_strength;
			stime_q <= cmd.shake_time;
			sfade_q <= cmd.shake_fade;
		end
		if (state_q == StExec) begin
			errx_q <= $signed({{2{tx_q[23]}}, tx_q}) - $signed({7'b0, vw_q, 7'b0})
			          - $signed({{2{pos_x_q[23]}}, pos_x_q});
			erry_q <= $signed({{2{ty_q[23]}}, ty_q}) - $signed({7'b0, vh_q, 7'b0})
			          - $signed({{2{pos_y_q[23]}}, pos_y_q});
		end
		if (state_q == StWait && mrsp.done) begin
			prod_q <= mrsp.p;
		end
		if (state_q == StPost && phase_q == PhGain) begin
			gd_q <= prod_q[31:0];
		end
		if (state_q == StPost && phase_q == PhMove) begin
			psat_q <= follow_pos;
		end
		if (state_q == StPost && phase_q == PhShake) begin
			n_q <= prod_q[25:0] + sfc_pkg::HalfDiv;
		end
		if (out_load) begin
			ox_q  <= pos_x_q;
			oy_q  <= pos_y_q;
			osh_q <= (rem_q != 24'd0);
		end
	end

	`ASSERT_RST(a_done_in_wait, clk, arst_n, mrsp.done |-> (state_q == StWait), "product arrived outside wait")
	`ASSERT_RST(a_rem_rise, clk, arst_n, (rem_q > $past(rem_q)) |-> ($past(state_q) == StExec && $past(op_q) == sfc_pkg::OpShake), "shake time grew without shake start")
	`ASSERT_RST(a_out_load, clk, arst_n, out_load |=> (ov_q && state_q == StIdle), "result load did not complete")
endmodule
`default_nettype wire

// File: sv/sfc_mul.sv
// digit-serial unsigned multiplier, 32x32 bits, one radix-16 digit per cycle
// depends on sfc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sfc_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfc_pkg::mul_req_t req,
	output sfc_pkg::mul_rsp_t      rsp
);
	localparam int MulW   = sfc_pkg::MulW;
	localparam int DigW   = sfc_pkg::MulDigitW;
	localparam int SumW   = MulW + DigW;
	localparam int CntW   = $clog2(sfc_pkg::MulDigits);
	localparam logic [CntW-1:0] LastDigit = CntW'(sfc_pkg::MulDigits - 1);

	logic [MulW-1:0] a_q;
	logic [MulW-1:0] b_q;
	logic [MulW-1:0] hi_q;
	logic [MulW-1:0] lo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [SumW-1:0] step_sum;

	assign step_sum = {{DigW{1'b0}}, hi_q} + SumW'(a_q) * SumW'(b_q[DigW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastDigit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			b_q  <= b_q >> DigW;
			hi_q <= step_sum[SumW-1:DigW];
			lo_q <= {step_sum[DigW-1:0], lo_q[MulW-1:DigW]};
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.p    = {hi_q, lo_q};
	end

	`ASSERT_RST(a_start_idle, clk, arst_n, req.start |-> !busy_q, "multiply started while busy")
	`ASSERT_RST(a_done_last, clk, arst_n,
		(busy_q && cnt_q == LastDigit && !req.start) |=> done_q, "missing done after last digit")
	`ASSERT_ALW(a_done_not_busy, clk, done_q |-> !busy_q, "done while still busy")
endmodule
`default_nettype wire
